/* rtl/assert_macros.svh */
// assertion macros used by the allocation tracking table unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ATT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ATT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/att_pkg.sv */
// types, constants and helper functions of the allocation tracking table
package att_pkg;

  localparam int ENTRIES   = 64;
  localparam int TAG_COUNT = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_W     = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int WORD_W    = 48 + 40 + TAG_W + 32;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_FREE   = 3'd1;
  localparam logic [2:0] CMD_ACCESS = 3'd2;
  localparam logic [2:0] CMD_FRAME  = 3'd3;
  localparam logic [2:0] CMD_SCAN   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic [47:0] MAX48 = '1;
  localparam logic [31:0] MAX32 = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_UPD, S_DISCH, S_CHARGE, S_WRITE, S_EMIT, S_SCAN_END
  } state_t;

  function automatic logic [TAG_W-1:0] map_tag(input logic [3:0] t);
    if (32'(t) < TAG_COUNT) map_tag = TAG_W'(t);
    else map_tag = '0;
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat48 = s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [47:0] sub_sat48(input logic [47:0] a, input logic [47:0] b);
    sub_sat48 = (b <= a) ? (a - b) : '0;
  endfunction

  function automatic logic [31:0] inc_sat32(input logic [31:0] c);
    inc_sat32 = (c == MAX32) ? c : c + 32'd1;
  endfunction

endpackage

/* rtl/att_ram.sv */
// generic single-write, registered-read ram
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/allocation_tracking_table_unit.sv */
// allocation tracking table: associative block table with byte and event statistics
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser cmd, tdata address/size/tag/frame/min_age
// m_*      out  m_tvalid/m_tready  tuser status, tdata statistics and stale record, tlast
//
// alloc, free and access walk the table slot by slot (ram read, then compare) and stop at a match;
// set frame and no-op events skip the walk and go straight to the result
// a stale scan walks every slot and holds while a stale record cannot enter the output register
// after the walk, the saturating subtract and add steps update the live totals
// sync reset clears valid bits, totals, counters and the frame; table words are not cleared
// s_tready is high only between events; a held result blocks the next one from leaving
`include "assert_macros.svh"

module allocation_tracking_table_unit import att_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [47:0] address, [87:48] size, [91:88] tag, [123:92] frame, [155:124] min_age
  input  logic [159:0] s_tdata,
  // [2:0] cmd
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [47:0] live_bytes, [95:48] peak_bytes, [143:96] tag_live_bytes,
  // [191:144] tag_peak_bytes, [223:192] total_allocs, [255:224] total_frees,
  // [287:256] missed_frees, [335:288] stale_address, [375:336] stale_size,
  // [407:376] stale_age
  output logic [407:0] m_tdata,
  // [1:0] status
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  state_t state, state_next;

  // latched event
  logic [2:0]       cmd;
  logic [47:0]      address;
  logic [39:0]      size;
  logic [TAG_W-1:0] tag_m;
  logic [31:0]      min_age;

  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_slot;
  logic               free_found;
  logic [IDX_W-1:0]   free_slot;
  logic [39:0]        e_size;
  logic [TAG_W-1:0]   e_tag;
  logic [47:0]        e_addr;

  logic [47:0] live_total, peak_total;
  logic [47:0] tag_live [TAG_COUNT];
  logic [47:0] tag_peak [TAG_COUNT];
  logic [31:0] alloc_count, free_count, missed_count, current_frame;

  logic [39:0]      d_size;
  logic [TAG_W-1:0] d_tag;
  logic [TAG_W-1:0] eff_tag;
  logic [1:0]       ev_status;

  logic             pend_valid;
  logic [47:0]      pend_addr;
  logic [39:0]      pend_size;
  logic [31:0]      pend_age;
  logic [TAG_W-1:0] pend_tag;

  // output register
  logic [47:0] o_live, o_peak, o_tlive, o_tpeak, o_saddr;
  logic [31:0] o_allocs, o_frees, o_missed, o_sage;
  logic [39:0] o_ssize;

  // table ram
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [47:0]         r_addr;
  logic [39:0]         r_size;
  logic [TAG_W-1:0]    r_tag;
  logic [31:0]         r_la;

  att_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign {r_la, r_tag, r_size, r_addr} = ram_rdata;

  logic        out_free;
  logic        out_load;
  logic        idx_last;
  logic        match;
  logic [31:0] age;
  logic        stale_hit;
  logic [47:0] live_add, live_sub, tlive_add, tlive_sub;
  logic        alloc_ok, write_ok;

  assign out_free  = !m_tvalid || m_tready;
  assign idx_last  = (idx == IDX_W'(ENTRIES - 1));
  assign match     = valid[idx] && (r_addr == address);
  assign age       = (current_frame >= r_la) ? (current_frame - r_la) : '0;
  assign stale_hit = valid[idx] && (age >= min_age);
  assign alloc_ok  = (s_tdata[47:0] != '0) && (s_tdata[87:48] != '0);
  assign write_ok  = hit || free_found;

  // a new word enters the output register
  assign out_load  = out_free && ((state == S_EMIT) || (state == S_SCAN_END) ||
                     (state == S_CHK && cmd == CMD_SCAN && stale_hit && pend_valid));

  assign live_sub  = sub_sat48(live_total, {8'd0, d_size});
  assign tlive_sub = sub_sat48(tag_live[d_tag], {8'd0, d_size});
  assign live_add  = add_sat48(live_total, {8'd0, size});
  assign tlive_add = add_sat48(tag_live[tag_m], {8'd0, size});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          priority case (s_tuser)
            CMD_ALLOC:  state_next = alloc_ok ? S_RD : S_EMIT;
            CMD_FREE:   state_next = (s_tdata[47:0] != '0) ? S_RD : S_EMIT;
            CMD_ACCESS,
            CMD_SCAN:   state_next = S_RD;
            default:    state_next = S_EMIT;
          endcase
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (cmd == CMD_SCAN) begin
          if (!(stale_hit && pend_valid && !out_free)) begin
            state_next = idx_last ? S_SCAN_END : S_RD;
          end
        end else if (match || idx_last) begin
          state_next = S_UPD;
        end else begin
          state_next = S_RD;
        end
      end
      S_UPD: begin
        priority case (cmd)
          CMD_ALLOC:  state_next = hit ? S_DISCH : S_CHARGE;
          CMD_FREE:   state_next = S_DISCH;
          default:    state_next = hit ? S_WRITE : S_EMIT;
        endcase
      end
      S_DISCH:    state_next = (cmd == CMD_ALLOC) ? S_CHARGE : S_EMIT;
      S_CHARGE:   state_next = write_ok ? S_WRITE : S_EMIT;
      S_WRITE:    state_next = S_EMIT;
      S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
      S_SCAN_END: state_next = out_free ? S_IDLE : S_SCAN_END;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = (state == S_IDLE);
    ram_we    = (state == S_WRITE);
    ram_waddr = hit ? hit_slot : free_slot;
    if (cmd == CMD_ALLOC) ram_wdata = {current_frame, tag_m, size, address};
    else ram_wdata = {current_frame, e_tag, e_size, e_addr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      live_total    <= '0;
      peak_total    <= '0;
      alloc_count   <= '0;
      free_count    <= '0;
      missed_count  <= '0;
      current_frame <= '0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < TAG_COUNT; i++) begin
        tag_live[i] <= '0;
        tag_peak[i] <= '0;
      end
    end else begin
      state <= state_next;
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd        <= s_tuser;
            address    <= s_tdata[47:0];
            size       <= s_tdata[87:48];
            tag_m      <= map_tag(s_tdata[91:88]);
            min_age    <= s_tdata[155:124];
            eff_tag    <= map_tag(s_tdata[91:88]);
            ev_status  <= ST_OK;
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            if (s_tuser == CMD_FRAME) current_frame <= s_tdata[123:92];
          end
        end
        S_RD: ;
        S_CHK: begin
          if (cmd == CMD_SCAN) begin
            if (!(stale_hit && pend_valid && !out_free)) begin
              if (stale_hit) begin
                if (pend_valid) begin
                  // previous record goes out; this one waits to learn if it is final
                  m_tuser  <= ST_STALE;
                  m_tlast  <= 1'b0;
                  o_live   <= live_total;
                  o_peak   <= peak_total;
                  o_tlive  <= tag_live[pend_tag];
                  o_tpeak  <= tag_peak[pend_tag];
                  o_allocs <= alloc_count;
                  o_frees  <= free_count;
                  o_missed <= missed_count;
                  o_saddr  <= pend_addr;
                  o_ssize  <= pend_size;
                  o_sage   <= pend_age;
                end
                pend_valid <= 1'b1;
                pend_addr  <= r_addr;
                pend_size  <= r_size;
                pend_age   <= age;
                pend_tag   <= map_tag(4'(r_tag));
              end
              if (!idx_last) idx <= idx + 1'b1;
            end
          end else begin
            if (match) begin
              hit      <= 1'b1;
              hit_slot <= idx;
              e_addr   <= r_addr;
              e_size   <= r_size;
              e_tag    <= map_tag(4'(r_tag));
            end else begin
              if (!valid[idx] && !free_found) begin
                free_found <= 1'b1;
                free_slot  <= idx;
              end
              if (!idx_last) idx <= idx + 1'b1;
            end
          end
        end
        S_UPD: begin
          priority case (cmd)
            CMD_ALLOC: begin
              d_size <= e_size;
              d_tag  <= e_tag;
              if (hit) free_count <= inc_sat32(free_count);
            end
            CMD_FREE: begin
              free_count <= inc_sat32(free_count);
              if (hit) begin
                d_size       <= e_size;
                d_tag        <= e_tag;
                eff_tag      <= e_tag;
                valid[hit_slot] <= 1'b0;
              end else begin
                d_size       <= size;
                d_tag        <= tag_m;
                missed_count <= inc_sat32(missed_count);
              end
            end
            default: begin
              if (hit) eff_tag <= e_tag;
            end
          endcase
        end
        S_DISCH: begin
          live_total      <= live_sub;
          tag_live[d_tag] <= tlive_sub;
        end
        S_CHARGE: begin
          live_total      <= live_add;
          tag_live[tag_m] <= tlive_add;
          if (live_add > peak_total) peak_total <= live_add;
          if (tlive_add > tag_peak[tag_m]) tag_peak[tag_m] <= tlive_add;
          alloc_count <= inc_sat32(alloc_count);
          if (!write_ok) ev_status <= ST_FULL;
        end
        S_WRITE: begin
          valid[ram_waddr] <= 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tuser  <= ev_status;
            m_tlast  <= 1'b1;
            o_live   <= live_total;
            o_peak   <= peak_total;
            o_tlive  <= tag_live[eff_tag];
            o_tpeak  <= tag_peak[eff_tag];
            o_allocs <= alloc_count;
            o_frees  <= free_count;
            o_missed <= missed_count;
            o_saddr  <= '0;
            o_ssize  <= '0;
            o_sage   <= '0;
          end
        end
        S_SCAN_END: begin
          if (out_free) begin
            m_tlast  <= 1'b1;
            o_live   <= live_total;
            o_peak   <= peak_total;
            o_allocs <= alloc_count;
            o_frees  <= free_count;
            o_missed <= missed_count;
            if (pend_valid) begin
              m_tuser <= ST_STALE;
              o_tlive <= tag_live[pend_tag];
              o_tpeak <= tag_peak[pend_tag];
              o_saddr <= pend_addr;
              o_ssize <= pend_size;
              o_sage  <= pend_age;
            end else begin
              m_tuser <= ST_NONE;
              o_tlive <= tag_live[eff_tag];
              o_tpeak <= tag_peak[eff_tag];
              o_saddr <= '0;
              o_ssize <= '0;
              o_sage  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {o_sage, o_ssize, o_saddr, o_missed, o_frees, o_allocs,
                    o_tpeak, o_tlive, o_peak, o_live};

  `ATT_ASSERT(a_peak_ge_live, peak_total >= live_total, "peak below live total")
  `ATT_ASSERT(a_live_only_in_update, (state != S_DISCH && state != S_CHARGE) |=> $stable(live_total), "live total moved outside update")
  `ATT_ASSERT(a_none_is_final, (m_tvalid && m_tuser == ST_NONE) |-> m_tlast, "empty scan result not final")
  `ATT_ASSERT(a_busy_not_ready, (state != S_IDLE) |-> !s_tready, "ready while event in flight")

endmodule
